/* hdl/psu_pkg.sv */
// ============================================================================
// psu_pkg
// Shared types and constants of the PNG scanline unfilter core.
// ============================================================================
package psu_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT       = 2'd2;

    localparam int ROW_BYTES_W = 13;
    localparam int BPP_W       = 4;
    localparam int ROW_COUNT_W = 16;

    // Window of recently rebuilt bytes (left and up-left neighbors)
    localparam int RECENT_DEPTH = 8;
    localparam int RECENT_IDX_W = 3;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Highest legal filter type
    localparam logic [7:0] FILT_MAX_CODE = 8'd4;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef enum logic {
        CMD_DATA  = 1'b0,
        CMD_ERROR = 1'b1
    } cmd_kind_t;

    // One classified word handed from front to back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        filter_t    filter;
        logic       row_first;
        logic       top_row;
        logic       row_end;
        logic       image_end;
    } psu_cmd_t;

    localparam int CMD_W = $bits(psu_cmd_t);

endpackage

/* hdl/psu_ram.sv */
// ============================================================================
// psu_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ============================================================================
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/psu_queue.sv */
// ============================================================================
// psu_queue
// Short register queue that decouples the classifier from the reconstructor.
// ============================================================================
module psu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output logic [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full   = (count_reg == CW'(DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> rvalid)
        else $error("queue read while empty");

endmodule

/* hdl/psu_front.sv */
// ============================================================================
// psu_front
// Byte classifier: tracks rows, columns, filter type and the sticky error.
// ============================================================================
module psu_front #(
    parameter int MAX_ROW_BYTES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          in_byte,
    input  logic                                in_start,
    input  logic [psu_pkg::ROW_BYTES_W-1:0]     row_bytes,
    input  logic [psu_pkg::ROW_COUNT_W-1:0]     row_count,
    input  logic                                q_full,
    output logic                                push,
    output psu_pkg::psu_cmd_t                   cmd,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]    cmd_col
);
    import psu_pkg::*;

    localparam int AW  = $clog2(MAX_ROW_BYTES);
    localparam int RBW = (AW + 1 > ROW_BYTES_W) ? AW + 1 : ROW_BYTES_W;
    localparam int RCW = ROW_COUNT_W + 1;

    logic [AW-1:0]          col_reg, col_next;
    logic [ROW_COUNT_W-1:0] row_reg, row_next;
    filter_t                filter_reg, filter_next;
    logic                   await_reg, await_next;
    logic                   err_reg, err_next;

    logic                   accept;
    logic [AW-1:0]          col_v;
    logic [ROW_COUNT_W-1:0] row_v;
    logic                   await_v;
    logic                   err_v;
    logic [RBW-1:0]         rb_eff;
    logic [ROW_COUNT_W-1:0] rc_eff;
    logic                   rend;
    logic                   iend;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Image start restarts the counters before the byte is classified
    assign col_v   = in_start ? '0 : col_reg;
    assign row_v   = in_start ? '0 : row_reg;
    assign await_v = in_start | await_reg;
    assign err_v   = in_start ? 1'b0 : err_reg;

    always_comb begin
        if (row_bytes == '0) begin
            rb_eff = RBW'(1);
        end else if (RBW'(row_bytes) > RBW'(MAX_ROW_BYTES)) begin
            rb_eff = RBW'(MAX_ROW_BYTES);
        end else begin
            rb_eff = RBW'(row_bytes);
        end
    end

    assign rc_eff  = (row_count == '0) ? ROW_COUNT_W'(1) : row_count;
    assign rend    = (RBW'(col_v) + RBW'(1)) >= rb_eff;
    assign iend    = rend && ((RCW'(row_v) + RCW'(1)) >= RCW'(rc_eff));
    assign cmd_col = col_v;

    always_comb begin
        col_next    = col_reg;
        row_next    = row_reg;
        filter_next = filter_reg;
        await_next  = await_reg;
        err_next    = err_reg;
        push        = 1'b0;
        cmd         = '0;
        if (accept) begin
            col_next   = col_v;
            row_next   = row_v;
            await_next = await_v;
            err_next   = err_v;
            if (!err_v) begin
                if (await_v) begin
                    if (in_byte > FILT_MAX_CODE) begin
                        err_next = 1'b1;
                        push     = 1'b1;
                        cmd.kind = CMD_ERROR;
                    end else begin
                        filter_next = filter_t'(in_byte[2:0]);
                        await_next  = 1'b0;
                        col_next    = '0;
                    end
                end else begin
                    push          = 1'b1;
                    cmd.kind      = CMD_DATA;
                    cmd.data      = in_byte;
                    cmd.filter    = filter_reg;
                    cmd.row_first = (col_v == '0);
                    cmd.top_row   = (row_v == '0);
                    cmd.row_end   = rend;
                    cmd.image_end = iend;
                    if (rend) begin
                        col_next   = '0;
                        await_next = 1'b1;
                        row_next   = iend ? '0 : row_v + ROW_COUNT_W'(1);
                    end else begin
                        col_next = col_v + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            filter_reg <= FILT_NONE;
            await_reg  <= 1'b1;
            err_reg    <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            filter_reg <= filter_next;
            await_reg  <= await_next;
            err_reg    <= err_next;
        end
    end

endmodule

/* hdl/psu_back.sv */
// ============================================================================
// psu_back
// Reconstructor: line store read, predictor, line store write, output word.
// ============================================================================
module psu_back #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  psu_pkg::psu_cmd_t                 q_cmd,
    input  logic [$clog2(MAX_ROW_BYTES)-1:0]  q_col,
    output logic                              q_pop,
    input  logic [psu_pkg::BPP_W-1:0]         bytes_per_pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_pixel,
    output logic                              out_row_end,
    output logic                              out_image_end,
    output logic                              out_bad
);
    import psu_pkg::*;

    localparam int AW = $clog2(MAX_ROW_BYTES);

    logic                s2_valid_reg, s2_valid_next;
    psu_cmd_t            s2_cmd_reg, s2_cmd_next;
    logic [AW-1:0]       s2_col_reg, s2_col_next;
    logic                fwd_reg, fwd_next;
    logic [7:0]          fwd_data_reg, fwd_data_next;
    logic [7:0]          recent_reg [RECENT_DEPTH];
    logic [7:0]          recent_next [RECENT_DEPTH];
    logic [7:0]          recent_up_reg [RECENT_DEPTH];
    logic [7:0]          recent_up_next [RECENT_DEPTH];
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_pixel_reg, out_pixel_next;
    logic                out_row_end_reg, out_row_end_next;
    logic                out_image_end_reg, out_image_end_next;
    logic                out_bad_reg, out_bad_next;

    logic                out_adv;
    logic                s2_adv;
    logic                s2_open;
    logic                s2_is_data;
    logic                ram_we;
    logic [7:0]          ram_rdata;
    logic [BPP_W-1:0]    bpp_eff;
    logic [RECENT_IDX_W-1:0] bidx;
    logic [7:0]          up_mem;
    logic [7:0]          nb_a, nb_b, nb_c;
    logic [8:0]          avg_sum;
    logic signed [9:0]   pa, pb, pc;
    logic [7:0]          paeth;
    logic [7:0]          pred;
    logic [7:0]          val;

    assign out_adv    = !out_valid_reg || out_ready;
    assign s2_adv     = s2_valid_reg && out_adv;
    assign s2_open    = !s2_valid_reg || out_adv;
    assign q_pop      = q_valid && s2_open;
    assign s2_is_data = (s2_cmd_reg.kind == CMD_DATA);
    assign ram_we     = s2_adv && s2_is_data;

    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s2_col_reg),
        .wdata (val),
        .re    (q_pop),
        .raddr (q_col),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (bytes_per_pixel == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = bytes_per_pixel;
        end
    end
    assign bidx = RECENT_IDX_W'(bpp_eff - BPP_W'(1));

    // Take the byte written alongside the read when both hit the same entry
    assign up_mem = fwd_reg ? fwd_data_reg : ram_rdata;
    assign nb_a   = s2_cmd_reg.row_first ? 8'd0 : recent_reg[bidx];
    assign nb_b   = s2_cmd_reg.top_row ? 8'd0 : up_mem;
    assign nb_c   = (s2_cmd_reg.row_first || s2_cmd_reg.top_row) ? 8'd0
                                                                 : recent_up_reg[bidx];

    assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
    assign pa = $signed({2'b00, nb_b}) - $signed({2'b00, nb_c});
    assign pb = $signed({2'b00, nb_a}) - $signed({2'b00, nb_c});
    assign pc = pa + pb;

    always_comb begin
        logic [9:0] da, db, dc;
        da = pa[9] ? 10'(-pa) : 10'(pa);
        db = pb[9] ? 10'(-pb) : 10'(pb);
        dc = pc[9] ? 10'(-pc) : 10'(pc);
        if (da <= db && da <= dc) begin
            paeth = nb_a;
        end else if (db <= dc) begin
            paeth = nb_b;
        end else begin
            paeth = nb_c;
        end
    end

    always_comb begin
        unique case (s2_cmd_reg.filter)
            FILT_SUB:   pred = nb_a;
            FILT_UP:    pred = nb_b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end
    assign val = s2_cmd_reg.data + pred;

    always_comb begin
        s2_valid_next = s2_valid_reg;
        s2_cmd_next   = s2_cmd_reg;
        s2_col_next   = s2_col_reg;
        fwd_next      = fwd_reg;
        fwd_data_next = fwd_data_reg;
        if (s2_open) begin
            s2_valid_next = q_valid;
            s2_cmd_next   = q_cmd;
            s2_col_next   = q_col;
        end
        if (q_pop) begin
            fwd_next      = ram_we && (s2_col_reg == q_col);
            fwd_data_next = val;
        end
    end

    // Shift the neighbor windows; a new row starts from zeros
    always_comb begin
        for (int i = 0; i < RECENT_DEPTH; i++) begin
            recent_next[i]    = recent_reg[i];
            recent_up_next[i] = recent_up_reg[i];
        end
        if (ram_we) begin
            for (int i = 1; i < RECENT_DEPTH; i++) begin
                recent_next[i]    = s2_cmd_reg.row_first ? 8'd0 : recent_reg[i-1];
                recent_up_next[i] = s2_cmd_reg.row_first ? 8'd0 : recent_up_reg[i-1];
            end
            recent_next[0]    = val;
            recent_up_next[0] = nb_b;
        end
    end

    always_comb begin
        out_valid_next     = out_valid_reg;
        out_pixel_next     = out_pixel_reg;
        out_row_end_next   = out_row_end_reg;
        out_image_end_next = out_image_end_reg;
        out_bad_next       = out_bad_reg;
        if (s2_adv) begin
            out_valid_next     = 1'b1;
            out_pixel_next     = s2_is_data ? val : 8'd0;
            out_row_end_next   = s2_is_data && s2_cmd_reg.row_end;
            out_image_end_next = s2_is_data && s2_cmd_reg.image_end;
            out_bad_next       = !s2_is_data;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int i = 0; i < RECENT_DEPTH; i++) begin
                recent_reg[i]    <= 8'd0;
                recent_up_reg[i] <= 8'd0;
            end
        end else begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            fwd_reg       <= fwd_next;
            for (int i = 0; i < RECENT_DEPTH; i++) begin
                recent_reg[i]    <= recent_next[i];
                recent_up_reg[i] <= recent_up_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        s2_cmd_reg        <= s2_cmd_next;
        s2_col_reg        <= s2_col_next;
        fwd_data_reg      <= fwd_data_next;
        out_pixel_reg     <= out_pixel_next;
        out_row_end_reg   <= out_row_end_next;
        out_image_end_reg <= out_image_end_next;
        out_bad_reg       <= out_bad_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_pixel     = out_pixel_reg;
    assign out_row_end   = out_row_end_reg;
    assign out_image_end = out_image_end_reg;
    assign out_bad       = out_bad_reg;

endmodule

/* hdl/png_scanline_unfilter_core.sv */
// Path: an accepted data byte passes a queue slot, the s2 register and the m_ register.
// Throughput: one byte per cycle while the queue is not full and m_tready is high; legal
//   filter-type bytes and bytes dropped after an error give no word. The line store has one
//   write and one read port, used once per byte. Reset: aresetn is synchronous, active low;
//   it clears the counters, the error flag, the queue and the pipeline. The line store is not cleared.
// ============================================================================
// png_scanline_unfilter_core
// PNG scanline filter reconstruction (none, sub, up, average, Paeth) on a
// byte stream, with a line store for the previous scanline.
// ============================================================================
module png_scanline_unfilter_core #(
    parameter int MAX_ROW_BYTES   = 4096,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port
    input  logic                              cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Filtered stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] filtered_byte
    input  logic                              s_tuser,   // [0] image_start

    // Rebuilt bytes out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] pixel_byte
    output logic                              m_tlast,   // row_end
    output logic [1:0]                        m_tuser    // [0] image_end, [1] bad_filter
);
    import psu_pkg::*;

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int QW = CMD_W + AW;

    // Configuration registers; write them only while the core is idle (the core does not enforce it)
    logic [ROW_BYTES_W-1:0] row_bytes_reg, row_bytes_next;
    logic [BPP_W-1:0]       bpp_reg, bpp_next;
    logic [ROW_COUNT_W-1:0] row_count_reg, row_count_next;

    // Front to queue
    logic                   f_push;
    psu_cmd_t               f_cmd;
    logic [AW-1:0]          f_col;

    // Queue to back
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic [QW-1:0]          q_rdata;
    psu_cmd_t               q_cmd;
    logic [AW-1:0]          q_col;

    always_comb begin
        row_bytes_next = row_bytes_reg;
        bpp_next       = bpp_reg;
        row_count_next = row_count_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ROW_BYTES:       row_bytes_next = cfg_data[ROW_BYTES_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_next       = cfg_data[BPP_W-1:0];
                REG_ROW_COUNT:       row_count_next = cfg_data[ROW_COUNT_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg <= ROW_BYTES_W'(1);
            bpp_reg       <= BPP_W'(1);
            row_count_reg <= ROW_COUNT_W'(1);
        end else begin
            row_bytes_reg <= row_bytes_next;
            bpp_reg       <= bpp_next;
            row_count_reg <= row_count_next;
        end
    end

    // Front: classify each word as filter type, data or error; track rows
    psu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .row_bytes (row_bytes_reg),
        .row_count (row_count_reg),
        .q_full    (q_full),
        .push      (f_push),
        .cmd       (f_cmd),
        .cmd_col   (f_col)
    );

    // Queue: hold classified words so each side can stall on its own
    psu_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_push),
        .wdata   ({f_col, f_cmd}),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    assign q_cmd = psu_cmd_t'(q_rdata[CMD_W-1:0]);
    assign q_col = q_rdata[QW-1:CMD_W];

    // Back: read the prior row, predict, write the rebuilt byte to the line store, present the word
    psu_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_col           (q_col),
        .q_pop           (q_pop),
        .bytes_per_pixel (bpp_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_pixel       (m_tdata),
        .out_row_end     (m_tlast),
        .out_image_end   (m_tuser[0]),
        .out_bad         (m_tuser[1])
    );

    a_bad_word_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 8'd0 && !m_tlast && !m_tuser[0]))
        else $error("error word carries data or end flags");

    a_image_end_ends_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("image end without row end");

endmodule
